/* hdl/stream_frame_deframer_top_macros.svh */
// ----------------------------------------------------------------------------
// Stream frame deframer assertion macros
// Shared concurrent assertion wrappers for the deframer checker.
// ----------------------------------------------------------------------------
`ifndef STREAM_FRAME_DEFRAMER_TOP_MACROS_SVH
`define STREAM_FRAME_DEFRAMER_TOP_MACROS_SVH

// Property checked only outside reset.
`define SFD_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("deframer check failed");

// Property checked at every edge, reset included.
`define SFD_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("deframer reset check failed");

`endif

/* hdl/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// Stream frame deframer package
// Types, codes and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

    localparam int unsigned HDR_BYTES = 20;
    localparam int unsigned HDR_CNT_W = 5;
    localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HDR_BYTES - 1);

    localparam logic [7:0] MAGIC_B0 = 8'h52;
    localparam logic [7:0] MAGIC_B1 = 8'h4D;
    localparam logic [7:0] MAGIC_B2 = 8'h50;
    localparam logic [7:0] MAGIC_B3 = 8'h31;

    localparam logic [31:0] FILE_CHUNK_LIMIT = 32'(28 + 512 * 1024);

    localparam logic [31:0] PAYLOAD_CAP_RST = 32'd1048576;
    localparam logic [7:0]  EXP_VERSION_RST = 8'd1;
    localparam logic [7:0]  FILE_TYPE_RST   = 8'd0;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_CAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_TYPE   = 2'd2;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ERR_MAGIC   = 2'd0;
    localparam logic [1:0] ERR_VERSION = 2'd1;
    localparam logic [1:0] ERR_LENGTH  = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [31:0] payload_cap;
        logic [7:0]  expected_version;
        logic [7:0]  file_chunk_type;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  frame_version;
        logic [7:0]  frame_type;
        logic [15:0] frame_flags;
        logic [31:0] payload_length;
        logic [63:0] msg_ident;
        logic [7:0]  data_out;
        logic        last;
        logic [1:0]  error_code;
    } result_t;

endpackage

`default_nettype wire

/* hdl/sfd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Holds the payload limit, expected version and file-chunk type.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data,
    output sfd_pkg::cfg_t                      cfg
);
    import sfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_PAYLOAD_CAP: cfg_next.payload_cap      = cfg_data;
                CFG_EXP_VERSION: cfg_next.expected_version = cfg_data[7:0];
                CFG_FILE_TYPE:   cfg_next.file_chunk_type  = cfg_data[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.payload_cap      <= PAYLOAD_CAP_RST;
            cfg_reg.expected_version <= EXP_VERSION_RST;
            cfg_reg.file_chunk_type  <= FILE_TYPE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/sfd_core.sv */
// ----------------------------------------------------------------------------
// Deframer core
// Header collection, header checks, payload count and sticky error state.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step,
    input  wire logic [7:0]    data_byte,
    input  sfd_pkg::cfg_t      cfg,
    output logic               has_result,
    output sfd_pkg::result_t   result
);
    import sfd_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [HDR_CNT_W-1:0]   hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]            remain_reg, remain_next;
    logic [1:0]             err_reg, err_next;
    logic [7:0]             hdr_store_reg [HDR_BYTES-1];

    logic [HDR_CNT_W-1:0]   hdr_idx;
    logic                   hdr_done;
    logic                   magic_ok;
    logic                   version_ok;
    logic                   length_ok;
    logic [31:0]            hdr_len;
    logic [31:0]            limit;
    logic [31:0]            remain_dec;

    assign hdr_idx  = (hdr_cnt_reg >= HDR_CNT_W'(HDR_BYTES)) ? '0 : hdr_cnt_reg;
    assign hdr_done = (hdr_idx == HDR_LAST);

    assign magic_ok = (hdr_store_reg[0] == MAGIC_B0) && (hdr_store_reg[1] == MAGIC_B1) &&
                      (hdr_store_reg[2] == MAGIC_B2) && (hdr_store_reg[3] == MAGIC_B3);
    assign version_ok = (hdr_store_reg[4] == cfg.expected_version);
    assign hdr_len    = {hdr_store_reg[8], hdr_store_reg[9],
                         hdr_store_reg[10], hdr_store_reg[11]};
    assign limit      = (hdr_store_reg[5] == cfg.file_chunk_type) ? FILE_CHUNK_LIMIT
                                                                  : cfg.payload_cap;
    assign length_ok  = (hdr_len <= limit);
    assign remain_dec = (remain_reg != '0) ? remain_reg - 32'd1 : remain_reg;

    // next state
    always_comb begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        remain_next  = remain_reg;
        err_next     = err_reg;
        if (step) begin
            case (phase_reg)
                PH_ERROR: begin
                    phase_next = PH_ERROR;
                end
                PH_PAYLOAD: begin
                    remain_next = remain_dec;
                    if (remain_dec == '0) begin
                        phase_next   = PH_HEADER;
                        hdr_cnt_next = '0;
                    end
                end
                default: begin
                    if (!hdr_done) begin
                        hdr_cnt_next = hdr_idx + HDR_CNT_W'(1);
                    end else begin
                        hdr_cnt_next = '0;
                        if (!magic_ok) begin
                            err_next   = ERR_MAGIC;
                            phase_next = PH_ERROR;
                        end else if (!version_ok) begin
                            err_next   = ERR_VERSION;
                            phase_next = PH_ERROR;
                        end else if (!length_ok) begin
                            err_next   = ERR_LENGTH;
                            phase_next = PH_ERROR;
                        end else if (hdr_len == '0) begin
                            phase_next = PH_HEADER;
                        end else begin
                            remain_next = hdr_len;
                            phase_next  = PH_PAYLOAD;
                        end
                    end
                end
            endcase
        end
    end

    // result
    always_comb begin
        has_result = 1'b0;
        result     = '0;
        case (phase_reg)
            PH_ERROR: begin
                has_result        = 1'b1;
                result.kind       = KIND_ERROR;
                result.error_code = err_reg;
            end
            PH_PAYLOAD: begin
                has_result      = 1'b1;
                result.kind     = KIND_PAYLOAD;
                result.data_out = data_byte;
                result.last     = (remain_dec == '0);
            end
            default: begin
                if (hdr_done) begin
                    has_result = 1'b1;
                    if (!magic_ok) begin
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_MAGIC;
                    end else if (!version_ok) begin
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_VERSION;
                    end else if (!length_ok) begin
                        result.kind       = KIND_ERROR;
                        result.error_code = ERR_LENGTH;
                    end else begin
                        result.kind           = KIND_HEADER;
                        result.frame_version  = hdr_store_reg[4];
                        result.frame_type     = hdr_store_reg[5];
                        result.frame_flags    = {hdr_store_reg[6], hdr_store_reg[7]};
                        result.payload_length = hdr_len;
                        result.msg_ident      = {hdr_store_reg[12], hdr_store_reg[13],
                                                 hdr_store_reg[14], hdr_store_reg[15],
                                                 hdr_store_reg[16], hdr_store_reg[17],
                                                 hdr_store_reg[18], data_byte};
                        result.last           = (hdr_len == '0);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            hdr_cnt_reg <= '0;
            remain_reg  <= '0;
            err_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            remain_reg  <= remain_next;
            err_reg     <= err_next;
        end
    end

    // last header byte is used straight from the input, never stored
    always_ff @(posedge aclk) begin
        if (step && (phase_reg != PH_PAYLOAD) && (phase_reg != PH_ERROR) && !hdr_done) begin
            hdr_store_reg[hdr_idx] <= data_byte;
        end
    end

endmodule

`default_nettype wire

/* hdl/stream_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// Stream frame deframer
// Splits a byte stream of length-prefixed frames into header and payload items.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one stream byte per transfer in s_tdata[7:0].
//   m_ channel: one result per transfer; m_tuser is the kind (header, payload,
//     error), m_tlast marks the final item of a frame, m_tdata the fields.
//   cfg channel: cfg_index 0 payload limit, 1 expected version, 2 file-chunk
//     type; write only while the block is idle. cfg_ready is always high.
//   Header bytes but the last produce no result; the last header byte yields
//     the header item or an error report; payload bytes pass through one each.
//   Path: a byte accepted into the input register is decoded when it advances,
//     and its result is then offered on m_ from the output register.
//   Throughput: one byte per cycle while m_tready is high, set by the input
//     register feeding the combinational decode into the output register.
//   Reset: aresetn low clears the phase, counters, error and both valid flags,
//     and restores the default configuration. No clearing pass is needed.
//   Stall: while m_tready is low one result waits in the output register and
//     one more byte is held in the input register; s_tready then drops.
//   Errors are sticky: every later byte yields an error report until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_frame_deframer_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,    // [7:0] data_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] frame_version, [15:8] frame_type, [31:16] frame_flags,
    // [63:32] payload_length, [127:64] msg_ident, [135:128] data_out,
    // [137:136] error_code, [143:138] zero
    output logic [143:0]                       m_tdata,
    output logic [1:0]                         m_tuser,    // [1:0] kind
    output logic                               m_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);
    import sfd_pkg::*;

    cfg_t       cfg;
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       advance;
    logic       has_result;
    result_t    result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    sfd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .data_byte  (in_data_reg),
        .cfg        (cfg),
        .has_result (has_result),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance && has_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
        if (advance && has_result) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {6'b0, out_reg.error_code, out_reg.data_out, out_reg.msg_ident,
                       out_reg.payload_length, out_reg.frame_flags, out_reg.frame_type,
                       out_reg.frame_version};

endmodule

`default_nettype wire

/* hdl/sfd_checker.sv */
// ----------------------------------------------------------------------------
// Deframer port checker
// Port-level assertions for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stream_frame_deframer_top_macros.svh"

module sfd_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tready,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [143:0] m_tdata,
    input  wire logic [1:0]   m_tuser,
    input  wire logic         m_tlast
);
    import sfd_pkg::*;

    logic seen_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_err_reg <= 1'b0;
        end else if (m_tvalid && m_tready && (m_tuser == KIND_ERROR)) begin
            seen_err_reg <= 1'b1;
        end
    end

    `SFD_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `SFD_ASSERT(a_err_sticky, aclk, aresetn, m_tvalid && seen_err_reg |-> m_tuser == KIND_ERROR)
    `SFD_ASSERT(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready)
    `SFD_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid)

endmodule

bind stream_frame_deframer_top sfd_checker u_sfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
